[src/gap_pkg.sv]
// Shared constants and codes for the grid path planner with cell occupancy.
package gap_pkg;

  // Map geometry: an 8 x 8 map, cell index is {x, y}
  localparam int GRID_DIM  = 8;
  localparam int CRD_W     = 3;
  localparam int CELLS     = 64;
  localparam int IDX_W     = 6;
  localparam int ID_BITS   = 8;
  localparam int COST_W    = 7;
  localparam int F_W       = 8;
  localparam int CMAP_W    = 2 + ID_BITS;
  localparam int SRCH_W    = 2 + COST_W;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 8;

  // Commands
  localparam logic [1:0] CMD_SET_OBST = 2'd0;
  localparam logic [1:0] CMD_OCCUPY   = 2'd1;
  localparam logic [1:0] CMD_VACATE   = 2'd2;
  localparam logic [1:0] CMD_FIND     = 2'd3;

  // Result status
  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_REFUSED = 2'd1;
  localparam logic [1:0] ST_NO_PATH = 2'd2;

  // Search marks
  localparam logic [1:0] MARK_NONE   = 2'd0;
  localparam logic [1:0] MARK_OPEN   = 2'd1;
  localparam logic [1:0] MARK_CLOSED = 2'd2;

  // Step directions
  localparam logic [1:0] DIR_XP = 2'd0;
  localparam logic [1:0] DIR_XN = 2'd1;
  localparam logic [1:0] DIR_YP = 2'd2;
  localparam logic [1:0] DIR_YN = 2'd3;

  typedef enum logic [12:0] {
    S_IDLE   = 13'h0001,
    S_CMD    = 13'h0002,
    S_RES    = 13'h0004,
    S_CLR    = 13'h0008,
    S_INIT   = 13'h0010,
    S_SCAN   = 13'h0020,
    S_PICK   = 13'h0040,
    S_EXP_RD = 13'h0080,
    S_EXP_EV = 13'h0100,
    S_TRC_WR = 13'h0200,
    S_TRC_RD = 13'h0400,
    S_OUT_RD = 13'h0800,
    S_OUT_LD = 13'h1000
  } state_e;

  function automatic logic [CRD_W-1:0] absdiff(input logic [CRD_W-1:0] a,
                                               input logic [CRD_W-1:0] b);
    absdiff = (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

[src/grid_astar_path_with_occupancy.sv]
// Grid path planner: cell map with occupancy and a memory-based A* search.
//
// Keeps an 8 x 8 cell map (obstacle, occupied, occupant id) and runs 4-connected
// A* with the Manhattan heuristic. Set obstacle, occupy and vacate each give
// one result. Find path first clears the search memory, then for each expanded
// cell scans all 64 search entries through the single read port of the search
// memory and checks up to four neighbours. The path is traced back from the
// goal and then goes out one cell per transaction, from start to goal. One item
// is worked at a time; a new item is taken once the last result of the previous
// one is in the output register.
module grid_astar_path_with_occupancy (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_tvalid_i,
  output logic                           s_tready_o,
  // command[1:0], cell_x[4:2], cell_y[7:5], goal_x[10:8], goal_y[13:11],
  // npc_id[21:14], obstacle_flag[22], zero fill
  input  logic [gap_pkg::IN_DATA_W-1:0]  s_tdata_i,
  output logic                           m_tvalid_o,
  input  logic                           m_tready_i,
  // step_x[2:0], step_y[5:3], status[7:6]
  output logic [gap_pkg::OUT_DATA_W-1:0] m_tdata_o,
  output logic                           m_tlast_o
);

  localparam int IW = gap_pkg::IDX_W;
  localparam int CW = gap_pkg::CRD_W;
  localparam int GW = gap_pkg::COST_W;

  gap_pkg::state_e state_q, state_d;

  // Request registers
  logic [1:0]                  cmd_q;
  logic [IW-1:0]               st_q, gl_q;
  logic [gap_pkg::ID_BITS-1:0] id_q;
  logic                        flag_q;
  logic [1:0]                  res_st_q;

  // Search registers
  logic [IW:0]        cnt_q;
  logic               pend_q;
  logic [IW-1:0]      ridx_q;
  logic               none_q;
  logic [IW-1:0]      cur_q;
  logic [gap_pkg::F_W-1:0] bf_q;
  logic [GW-1:0]      bg_q;
  logic [1:0]         dir_q;
  logic [IW-1:0]      nb_q;
  logic [IW-1:0]      p_q;

  // Output register
  logic                 ov_q;
  logic [CW-1:0]        ox_q, oy_q;
  logic [1:0]           ost_q;
  logic                 olast_q;

  // Memories
  logic [gap_pkg::CMAP_W-1:0] cmap_mem [gap_pkg::CELLS];
  logic [gap_pkg::CELLS-1:0]  cmap_vld_q;
  logic [gap_pkg::SRCH_W-1:0] srch_mem [gap_pkg::CELLS];
  logic [1:0]                 par_mem  [gap_pkg::CELLS];
  logic [IW-1:0]              path_mem [gap_pkg::CELLS];

  logic                       cmap_re, cmap_we;
  logic [IW-1:0]              cmap_ra, cmap_wa;
  logic [gap_pkg::CMAP_W-1:0] cmap_wd, cmap_rq, cmap_rd;
  logic                       cmap_rv;
  logic                       srch_re, srch_we;
  logic [IW-1:0]              srch_ra, srch_wa;
  logic [gap_pkg::SRCH_W-1:0] srch_wd, srch_rd;
  logic                       par_re, par_we;
  logic [IW-1:0]              par_ra, par_wa;
  logic [1:0]                 par_wd, par_rd;
  logic                       path_re, path_we;
  logic [IW-1:0]              path_ra, path_wa;
  logic [IW-1:0]              path_rd;

  // Input unpack
  logic [1:0]    in_cmd;
  logic [CW-1:0] in_x, in_y, in_gx, in_gy;
  logic          in_acc, out_free, out_ld, off_map, goal_off;

  assign in_cmd = s_tdata_i[1:0];
  assign in_x   = s_tdata_i[4:2];
  assign in_y   = s_tdata_i[7:5];
  assign in_gx  = s_tdata_i[10:8];
  assign in_gy  = s_tdata_i[13:11];

  assign s_tready_o = (state_q == gap_pkg::S_IDLE);
  assign in_acc     = s_tvalid_i && s_tready_o;
  assign out_free   = !ov_q || m_tready_i;
  assign out_ld     = out_free && ((state_q == gap_pkg::S_RES) || (state_q == gap_pkg::S_OUT_LD));
  assign off_map    = (32'(in_x) >= gap_pkg::GRID_DIM) || (32'(in_y) >= gap_pkg::GRID_DIM);
  assign goal_off   = (32'(in_gx) >= gap_pkg::GRID_DIM) || (32'(in_gy) >= gap_pkg::GRID_DIM);

  // Cell map entry as read, unwritten entries read as free
  assign cmap_rd = cmap_rv ? cmap_rq : '0;

  // Scan evaluation
  logic [GW-1:0]           sc_g;
  logic [gap_pkg::F_W-1:0] sc_f;
  logic                    sc_take;
  assign sc_g = srch_rd[GW-1:0];
  assign sc_f = gap_pkg::F_W'(sc_g)
              + gap_pkg::F_W'(gap_pkg::absdiff(ridx_q[5:3], gl_q[5:3]))
              + gap_pkg::F_W'(gap_pkg::absdiff(ridx_q[2:0], gl_q[2:0]));
  assign sc_take = pend_q && (srch_rd[GW+1:GW] == gap_pkg::MARK_OPEN)
                 && (none_q || sc_f < bf_q || (sc_f == bf_q && sc_g > bg_q));

  // Neighbour address and bounds
  logic [CW-1:0] cx, cy;
  logic          nb_ok;
  logic [IW-1:0] nb_idx;
  assign cx = cur_q[5:3];
  assign cy = cur_q[2:0];
  always_comb begin
    nb_ok  = 1'b1;
    nb_idx = cur_q;
    case (dir_q)
      gap_pkg::DIR_XP: begin
        nb_ok  = (32'(cx) + 1) < gap_pkg::GRID_DIM;
        nb_idx = {cx + 3'd1, cy};
      end
      gap_pkg::DIR_XN: begin
        nb_ok  = (cx != '0);
        nb_idx = {cx - 3'd1, cy};
      end
      gap_pkg::DIR_YP: begin
        nb_ok  = (32'(cy) + 1) < gap_pkg::GRID_DIM;
        nb_idx = {cx, cy + 3'd1};
      end
      default: begin
        nb_ok  = (cy != '0);
        nb_idx = {cx, cy - 3'd1};
      end
    endcase
  end

  // Neighbour evaluation
  logic          nb_blk, nb_upd;
  logic [GW-1:0] ng;
  assign ng     = bg_q + 7'd1;
  assign nb_blk = cmap_rd[0] || (cmap_rd[1] && (cmap_rd[gap_pkg::CMAP_W-1:2] != id_q));
  assign nb_upd = (srch_rd[GW+1:GW] != gap_pkg::MARK_CLOSED) && !nb_blk
                && ((srch_rd[GW+1:GW] == gap_pkg::MARK_NONE) || (ng < srch_rd[GW-1:0]));

  // Parent step back
  logic [IW-1:0] p_prev;
  always_comb begin
    case (par_rd)
      gap_pkg::DIR_XP: p_prev = p_q - 6'd8;
      gap_pkg::DIR_XN: p_prev = p_q + 6'd8;
      gap_pkg::DIR_YP: p_prev = p_q - 6'd1;
      default:         p_prev = p_q + 6'd1;
    endcase
  end

  // Cell command outcome
  logic                       cmd_ok;
  logic [gap_pkg::CMAP_W-1:0] cmd_new;
  always_comb begin
    cmd_ok  = 1'b1;
    cmd_new = cmap_rd;
    case (cmd_q)
      gap_pkg::CMD_SET_OBST: cmd_new = {cmap_rd[gap_pkg::CMAP_W-1:1], flag_q};
      gap_pkg::CMD_OCCUPY: begin
        cmd_ok  = !cmap_rd[0] && !cmap_rd[1];
        cmd_new = {id_q, 1'b1, 1'b0};
      end
      default: begin
        cmd_ok  = !cmap_rd[0] && cmap_rd[1] && (cmap_rd[gap_pkg::CMAP_W-1:2] == id_q);
        cmd_new = '0;
      end
    endcase
  end

  // Memory port control
  always_comb begin
    cmap_re = 1'b0; cmap_ra = {in_x, in_y};
    cmap_we = 1'b0; cmap_wa = st_q; cmap_wd = cmd_new;
    srch_re = 1'b0; srch_ra = cnt_q[IW-1:0];
    srch_we = 1'b0; srch_wa = cnt_q[IW-1:0]; srch_wd = '0;
    par_re  = 1'b0; par_ra  = p_q;
    par_we  = 1'b0; par_wa  = nb_q; par_wd = dir_q;
    path_re = 1'b0; path_ra = cnt_q[IW-1:0];
    path_we = 1'b0; path_wa = cnt_q[IW-1:0];
    case (state_q)
      gap_pkg::S_IDLE: cmap_re = in_acc && (in_cmd != gap_pkg::CMD_FIND) && !off_map;
      gap_pkg::S_CMD:  cmap_we = cmd_ok;
      gap_pkg::S_CLR:  srch_we = 1'b1;
      gap_pkg::S_INIT: begin
        srch_we = 1'b1;
        srch_wa = st_q;
        srch_wd = {gap_pkg::MARK_OPEN, 7'd0};
      end
      gap_pkg::S_SCAN: srch_re = !cnt_q[IW];
      gap_pkg::S_PICK: begin
        srch_we = !none_q;
        srch_wa = cur_q;
        srch_wd = {gap_pkg::MARK_CLOSED, bg_q};
      end
      gap_pkg::S_EXP_RD: begin
        srch_re = nb_ok;
        srch_ra = nb_idx;
        cmap_re = nb_ok;
        cmap_ra = nb_idx;
      end
      gap_pkg::S_EXP_EV: begin
        srch_we = nb_upd;
        srch_wa = nb_q;
        srch_wd = {gap_pkg::MARK_OPEN, ng};
        par_we  = nb_upd;
      end
      gap_pkg::S_TRC_WR: begin
        path_we = 1'b1;
        par_re  = 1'b1;
      end
      gap_pkg::S_OUT_RD: path_re = 1'b1;
      default: ;
    endcase
  end

  // Memory arrays
  always_ff @(posedge clk_i) begin
    if (cmap_we) cmap_mem[cmap_wa] <= cmap_wd;
    if (cmap_re) cmap_rq <= cmap_mem[cmap_ra];
    if (srch_we) srch_mem[srch_wa] <= srch_wd;
    if (srch_re) srch_rd <= srch_mem[srch_ra];
    if (par_we)  par_mem[par_wa] <= par_wd;
    if (par_re)  par_rd <= par_mem[par_ra];
    if (path_we) path_mem[path_wa] <= p_q;
    if (path_re) path_rd <= path_mem[path_ra];
  end

  // Cell map valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmap_vld_q <= '0;
      cmap_rv    <= 1'b0;
    end else begin
      if (cmap_we) cmap_vld_q[cmap_wa] <= 1'b1;
      if (cmap_re) cmap_rv <= cmap_vld_q[cmap_ra];
    end
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      gap_pkg::S_IDLE: begin
        if (in_acc) begin
          if (in_cmd == gap_pkg::CMD_FIND) begin
            state_d = (off_map || goal_off) ? gap_pkg::S_RES : gap_pkg::S_CLR;
          end else begin
            state_d = off_map ? gap_pkg::S_RES : gap_pkg::S_CMD;
          end
        end
      end
      gap_pkg::S_CMD:    state_d = gap_pkg::S_RES;
      gap_pkg::S_RES:    if (out_free) state_d = gap_pkg::S_IDLE;
      gap_pkg::S_CLR:    if (cnt_q[IW-1:0] == '1) state_d = gap_pkg::S_INIT;
      gap_pkg::S_INIT:   state_d = gap_pkg::S_SCAN;
      gap_pkg::S_SCAN:   if (cnt_q[IW] && !pend_q) state_d = gap_pkg::S_PICK;
      gap_pkg::S_PICK: begin
        if (none_q)            state_d = gap_pkg::S_RES;
        else if (cur_q == gl_q) state_d = gap_pkg::S_TRC_WR;
        else                   state_d = gap_pkg::S_EXP_RD;
      end
      gap_pkg::S_EXP_RD: begin
        if (nb_ok)                        state_d = gap_pkg::S_EXP_EV;
        else if (dir_q == gap_pkg::DIR_YN) state_d = gap_pkg::S_SCAN;
      end
      gap_pkg::S_EXP_EV:
        state_d = (dir_q == gap_pkg::DIR_YN) ? gap_pkg::S_SCAN : gap_pkg::S_EXP_RD;
      gap_pkg::S_TRC_WR:
        state_d = (p_q == st_q || cnt_q[IW-1:0] == '1) ? gap_pkg::S_OUT_RD
                                                       : gap_pkg::S_TRC_RD;
      gap_pkg::S_TRC_RD: state_d = gap_pkg::S_TRC_WR;
      gap_pkg::S_OUT_RD: state_d = gap_pkg::S_OUT_LD;
      gap_pkg::S_OUT_LD: begin
        if (out_free) state_d = (cnt_q == '0) ? gap_pkg::S_IDLE : gap_pkg::S_OUT_RD;
      end
      default: state_d = gap_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gap_pkg::S_IDLE;
      ov_q    <= 1'b0;
      pend_q  <= 1'b0;
      none_q  <= 1'b1;
      cnt_q   <= '0;
      dir_q   <= gap_pkg::DIR_XP;
    end else begin
      state_q <= state_d;
      if (out_ld)          ov_q <= 1'b1;
      else if (m_tready_i) ov_q <= 1'b0;
      case (state_q)
        gap_pkg::S_IDLE: begin
          cnt_q <= '0;
          if (in_acc) begin
            res_st_q <= (in_cmd == gap_pkg::CMD_FIND) ? gap_pkg::ST_NO_PATH
                                                      : gap_pkg::ST_REFUSED;
          end
        end
        gap_pkg::S_CMD: res_st_q <= cmd_ok ? gap_pkg::ST_DONE : gap_pkg::ST_REFUSED;
        gap_pkg::S_RES: begin
          if (out_free) begin
            ox_q    <= '0;
            oy_q    <= '0;
            ost_q   <= res_st_q;
            olast_q <= 1'b1;
          end
        end
        gap_pkg::S_CLR: cnt_q <= cnt_q + 7'd1;
        gap_pkg::S_INIT: begin
          cnt_q  <= '0;
          pend_q <= 1'b0;
          none_q <= 1'b1;
        end
        gap_pkg::S_SCAN: begin
          pend_q <= !cnt_q[IW];
          ridx_q <= cnt_q[IW-1:0];
          if (!cnt_q[IW]) cnt_q <= cnt_q + 7'd1;
          if (sc_take) begin
            none_q <= 1'b0;
            cur_q  <= ridx_q;
            bf_q   <= sc_f;
            bg_q   <= sc_g;
          end
        end
        gap_pkg::S_PICK: begin
          dir_q <= gap_pkg::DIR_XP;
          cnt_q <= '0;
          p_q   <= cur_q;
        end
        gap_pkg::S_EXP_RD: begin
          nb_q <= nb_idx;
          if (!nb_ok) dir_q <= dir_q + 2'd1;
          if (!nb_ok && dir_q == gap_pkg::DIR_YN) begin
            cnt_q  <= '0;
            none_q <= 1'b1;
            pend_q <= 1'b0;
          end
        end
        gap_pkg::S_EXP_EV: begin
          dir_q <= dir_q + 2'd1;
          if (dir_q == gap_pkg::DIR_YN) begin
            cnt_q  <= '0;
            none_q <= 1'b1;
            pend_q <= 1'b0;
          end
        end
        gap_pkg::S_TRC_WR: begin
          if (!(p_q == st_q || cnt_q[IW-1:0] == '1)) cnt_q <= cnt_q + 7'd1;
        end
        gap_pkg::S_TRC_RD: p_q <= p_prev;
        gap_pkg::S_OUT_LD: begin
          if (out_free) begin
            ox_q    <= path_rd[5:3];
            oy_q    <= path_rd[2:0];
            ost_q   <= gap_pkg::ST_DONE;
            olast_q <= (cnt_q == '0);
            if (cnt_q != '0) cnt_q <= cnt_q - 7'd1;
          end
        end
        default: ;
      endcase
    end
  end

  // Request capture
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cmd_q  <= in_cmd;
      st_q   <= {in_x, in_y};
      gl_q   <= {in_gx, in_gy};
      id_q   <= s_tdata_i[21:14];
      flag_q <= s_tdata_i[22];
    end
  end

  assign m_tvalid_o = ov_q;
  assign m_tdata_o  = {ost_q, oy_q, ox_q};
  assign m_tlast_o  = olast_q;

endmodule
